// ----- hw/rtl/ellipsoid_shell_repulsion_force_macros.svh -----
`ifndef ELLIPSOID_SHELL_REPULSION_FORCE_MACROS_SVH
`define ELLIPSOID_SHELL_REPULSION_FORCE_MACROS_SVH

// clocked property, quiet while in reset
`define ESRF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("esrf check failed");

// expression that must never hold
`define ESRF_ASSERT_NEVER(label, expr) `ESRF_ASSERT(label, !(expr))

`endif

// ----- hw/rtl/esrf_pkg.sv -----
package esrf_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int DW          = COORD_WIDTH + 1;
  localparam int AW          = COORD_WIDTH + 1;
  localparam int SW          = 2 * AW;
  localparam int A2W         = 2 * COORD_WIDTH;
  localparam int GUARD       = 8;
  localparam int XW          = SW + 2 * GUARD;
  localparam int RTW         = XW / 2;
  localparam int FRAC        = 12;
  localparam int TEST_FRAC   = 24;
  localparam int QTW         = TEST_FRAC + 1;
  localparam int TW          = TEST_FRAC + 2;
  localparam int TSW         = TW + 2;
  localparam int UNIT_FRAC   = 24;
  localparam int UW          = UNIT_FRAC + 1;
  localparam int STIFF_W     = 24;
  localparam int FORCE_W     = 24;
  localparam int ENERGY_W    = 32;
  localparam int REG_W       = 60;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * FORCE_W + ENERGY_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX       = 3'd4;

  localparam logic [REG_W-1:0] INNER_RESET = 60'h010000100001000;
  localparam logic [REG_W-1:0] OUTER_RESET = 60'h000010000100001;

  typedef logic signed [DW-1:0] disp_t;
  typedef disp_t [2:0] disp3_t;

  typedef struct packed {
    logic [STIFF_W-1:0] stiffness;
    logic [REG_W-1:0]   center;
    logic [REG_W-1:0]   inner;
    logic [REG_W-1:0]   outer;
    logic [REG_W-1:0]   box;
  } cfg_t;

  function automatic logic [COORD_WIDTH-1:0] field_of(input logic [REG_W-1:0] r,
                                                      input int axis);
    logic [63:0] w;
    w = 64'(r) >> (axis * COORD_WIDTH);
    return w[COORD_WIDTH-1:0];
  endfunction

endpackage

// ----- hw/rtl/esrf_wrap.sv -----
module esrf_wrap (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [2:0][esrf_pkg::COORD_WIDTH-1:0]  pos_i,
  input  esrf_pkg::cfg_t                         cfg_i,
  output logic                                   valid_o,
  output esrf_pkg::disp3_t                       d_o
);
  import esrf_pkg::*;

  localparam int NS = AW;
  localparam int CW = COORD_WIDTH;

  logic [NS:0]     vld_q;
  logic            vld_out_q;
  disp_t           v_q   [NS+1][3];
  logic [AW-1:0]   num_q [NS][3];
  logic [CW-1:0]   rem_q [NS+1][3];
  logic [CW-1:0]   ctr   [3];
  logic [CW-1:0]   side  [3];
  disp_t           v_d   [3];
  logic [AW-1:0]   num_d [3];
  logic [CW:0]     trial [NS][3];
  logic [CW-1:0]   rnx   [NS][3];
  logic [CW-1:0]   r1    [3];
  disp3_t          d_d;
  disp3_t          d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr[i]  = field_of(cfg_i.center, i);
      side[i] = field_of(cfg_i.box, i);
      v_d[i]  = $signed({pos_i[i][CW-1], pos_i[i]}) - $signed({ctr[i][CW-1], ctr[i]});
      num_d[i] = v_d[i][DW-1] ? AW'(-v_d[i]) : AW'(v_d[i]);
    end
    for (int k = 0; k < NS; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial[k][i] = {rem_q[k][i], num_q[k][i][AW-1]};
        if (trial[k][i] >= {1'b0, side[i]}) begin
          rnx[k][i] = CW'(trial[k][i] - {1'b0, side[i]});
        end else begin
          rnx[k][i] = trial[k][i][CW-1:0];
        end
      end
    end
    // fold the remainder into the half-open minimum image range
    for (int i = 0; i < 3; i++) begin
      r1[i] = (v_q[NS][i][DW-1] && (rem_q[NS][i] != '0)) ? side[i] - rem_q[NS][i]
                                                          : rem_q[NS][i];
      if (side[i] == '0) begin
        d_d[i] = v_q[NS][i];
      end else if ({r1[i], 1'b0} >= {1'b0, side[i]}) begin
        d_d[i] = $signed({1'b0, r1[i]}) - $signed({1'b0, side[i]});
      end else begin
        d_d[i] = $signed({1'b0, r1[i]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NS-1:0], valid_i};
      vld_out_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v_q[0][i]   <= v_d[i];
        num_q[0][i] <= num_d[i];
        rem_q[0][i] <= '0;
      end
      for (int k = 0; k < NS; k++) begin
        for (int i = 0; i < 3; i++) begin
          v_q[k+1][i]   <= v_q[k][i];
          rem_q[k+1][i] <= rnx[k][i];
        end
      end
      for (int k = 0; k < NS - 1; k++) begin
        for (int i = 0; i < 3; i++) begin
          num_q[k+1][i] <= {num_q[k][i][AW-2:0], 1'b0};
        end
      end
      d_q <= d_d;
    end
  end

  assign valid_o = vld_out_q;
  assign d_o     = d_q;

endmodule

// ----- hw/rtl/esrf_shell.sv -----
module esrf_shell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  esrf_pkg::disp3_t          d_i,
  input  esrf_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output esrf_pkg::disp3_t          d_o,
  output logic [esrf_pkg::SW-1:0]   s_o,
  output logic                      free_o
);
  import esrf_pkg::*;

  localparam int NQ = QTW;
  localparam logic [TW-1:0]  TCAP = TW'(1) << (TEST_FRAC + 1);
  localparam logic [TSW-1:0] ONE  = TSW'(1) << TEST_FRAC;

  logic [A2W-1:0] a2_q  [2][3];
  logic [A2W-1:0] a2_d  [2][3];
  logic [COORD_WIDTH-1:0] ra [2][3];
  logic [NQ:0]    vld_q;
  logic           vld_out_q;
  disp3_t         d_q   [NQ+1];
  logic [SW-1:0]  rem_q [NQ][2][3];
  logic [QTW-1:0] q_q   [NQ+1][2][3];
  logic           cap_q [1:NQ][2][3];
  logic           zro_q [1:NQ][2][3];
  logic [SW-1:0]  s_q   [1:NQ];
  logic [AW-1:0]  ad    [3];
  logic [SW-1:0]  d2_d  [3];
  logic [SW-1:0]  rin   [NQ][2][3];
  logic           ge    [NQ][2][3];
  logic [SW-1:0]  rnx   [NQ][2][3];
  logic           cap_d [2][3];
  logic           zro_d [2][3];
  logic [SW-1:0]  s_d;
  logic [TW-1:0]  term  [2][3];
  logic [TSW-1:0] sum   [2];
  disp3_t         d_out_q;
  logic [SW-1:0]  s_out_q;
  logic           free_q;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        ra[e][i] = (e == 0) ? field_of(cfg_i.inner, i) : field_of(cfg_i.outer, i);
        a2_d[e][i] = ra[e][i] * ra[e][i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      ad[i]   = d_i[i][DW-1] ? AW'(-d_i[i]) : AW'(d_i[i]);
      d2_d[i] = ad[i] * ad[i];
    end
    s_d = rem_q[0][0][0] + rem_q[0][0][1] + rem_q[0][0][2];
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        cap_d[e][i] = (rem_q[0][e][i] >= SW'({a2_q[e][i], 1'b0})) && (rem_q[0][e][i] != '0);
        zro_d[e][i] = (a2_q[e][i] == '0);
      end
    end
    for (int k = 0; k < NQ; k++) begin
      for (int e = 0; e < 2; e++) begin
        for (int i = 0; i < 3; i++) begin
          rin[k][e][i] = (k == 0) ? rem_q[k][e][i] : {rem_q[k][e][i][SW-2:0], 1'b0};
          ge[k][e][i]  = rin[k][e][i] >= SW'(a2_q[e][i]);
          rnx[k][e][i] = ge[k][e][i] ? rin[k][e][i] - SW'(a2_q[e][i]) : rin[k][e][i];
        end
      end
    end
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        if (cap_q[NQ][e][i]) begin
          term[e][i] = TCAP;
        end else if (zro_q[NQ][e][i]) begin
          term[e][i] = '0;
        end else begin
          term[e][i] = {1'b0, q_q[NQ][e][i]};
        end
      end
      sum[e] = TSW'(term[e][0]) + TSW'(term[e][1]) + TSW'(term[e][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q <= a2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NQ-1:0], valid_i};
      vld_out_q <= vld_q[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= d_i;
      for (int e = 0; e < 2; e++) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[0][e][i] <= d2_d[i];
          q_q[0][e][i]   <= '0;
          cap_q[1][e][i] <= cap_d[e][i];
          zro_q[1][e][i] <= zro_d[e][i];
        end
      end
      s_q[1] <= s_d;
      for (int k = 0; k < NQ; k++) begin
        d_q[k+1] <= d_q[k];
        for (int e = 0; e < 2; e++) begin
          for (int i = 0; i < 3; i++) begin
            q_q[k+1][e][i] <= {q_q[k][e][i][QTW-2:0], ge[k][e][i]};
          end
        end
      end
      for (int k = 0; k < NQ - 1; k++) begin
        for (int e = 0; e < 2; e++) begin
          for (int i = 0; i < 3; i++) begin
            rem_q[k+1][e][i] <= rnx[k][e][i];
          end
        end
      end
      for (int k = 1; k < NQ; k++) begin
        s_q[k+1]   <= s_q[k];
        cap_q[k+1] <= cap_q[k];
        zro_q[k+1] <= zro_q[k];
      end
      d_out_q <= d_q[NQ];
      s_out_q <= s_q[NQ];
      free_q  <= (sum[0] < ONE) && (sum[1] > ONE);
    end
  end

  assign valid_o = vld_out_q;
  assign d_o     = d_out_q;
  assign s_o     = s_out_q;
  assign free_o  = free_q;

endmodule

// ----- hw/rtl/esrf_sqrt.sv -----
module esrf_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  esrf_pkg::disp3_t          d_i,
  input  logic [esrf_pkg::SW-1:0]   s_i,
  input  logic                      free_i,
  output logic                      valid_o,
  output esrf_pkg::disp3_t          d_o,
  output logic [esrf_pkg::RTW-1:0]  root_o,
  output logic                      free_o
);
  import esrf_pkg::*;

  localparam int RMW = RTW + 2;

  logic           vld_q  [1:RTW];
  disp3_t         d_q    [1:RTW];
  logic           free_q [1:RTW];
  logic [RTW-1:0] root_q [1:RTW];
  logic [RMW-1:0] rem_q  [1:RTW-1];
  logic [XW-1:0]  x_q    [1:RTW-1];
  logic [RMW-1:0] src_rem  [RTW];
  logic [RTW-1:0] src_root [RTW];
  logic [XW-1:0]  src_x    [RTW];
  logic [RMW-1:0] t        [RTW];
  logic [RMW-1:0] trial    [RTW];
  logic           ge       [RTW];
  logic [RMW-1:0] rnx      [RTW];

  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_x[0]    = {s_i, {(2 * GUARD){1'b0}}};
    for (int k = 1; k < RTW; k++) begin
      src_rem[k]  = rem_q[k];
      src_root[k] = root_q[k];
      src_x[k]    = x_q[k];
    end
    // one root digit a stage
    for (int k = 0; k < RTW; k++) begin
      t[k]     = {src_rem[k][RMW-3:0], src_x[k][XW-1 -: 2]};
      trial[k] = {src_root[k], 2'b01};
      ge[k]    = t[k] >= trial[k];
      rnx[k]   = ge[k] ? t[k] - trial[k] : t[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= RTW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[1] <= valid_i;
      for (int k = 1; k < RTW; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[1]    <= d_i;
      free_q[1] <= free_i;
      for (int k = 1; k < RTW; k++) begin
        d_q[k+1]    <= d_q[k];
        free_q[k+1] <= free_q[k];
      end
      for (int k = 0; k < RTW; k++) begin
        root_q[k+1] <= {src_root[k][RTW-2:0], ge[k]};
      end
      for (int k = 0; k < RTW - 1; k++) begin
        rem_q[k+1] <= rnx[k];
        x_q[k+1]   <= {src_x[k][XW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[RTW];
  assign d_o     = d_q[RTW];
  assign root_o  = root_q[RTW];
  assign free_o  = free_q[RTW];

endmodule

// ----- hw/rtl/esrf_force.sv -----
module esrf_force (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  esrf_pkg::disp3_t                      d_i,
  input  logic [esrf_pkg::RTW-1:0]              root_i,
  input  logic                                  free_i,
  input  logic [esrf_pkg::STIFF_W-1:0]          stiffness_i,
  output logic                                  valid_o,
  output logic [2:0][esrf_pkg::FORCE_W-1:0]     force_o,
  output logic [esrf_pkg::ENERGY_W-1:0]         energy_o,
  output logic                                  free_o
);
  import esrf_pkg::*;

  localparam int UF   = UNIT_FRAC;
  localparam int PW   = STIFF_W + UW;
  localparam int EPW  = STIFF_W + RTW;
  localparam int ESH  = FRAC + GUARD;
  localparam int MAGW = PW + 1 - UF;
  localparam int EVW  = EPW + 1 - ESH;
  localparam logic [UW-1:0]       UCAP  = UW'(1) << UF;
  localparam logic [PW:0]         HALFU = (PW + 1)'(1) << (UF - 1);
  localparam logic [EPW:0]        HALFE = (EPW + 1)'(1) << (ESH - 1);
  localparam logic [MAGW-1:0]     FHALF = MAGW'(1) << (FORCE_W - 1);
  localparam logic [MAGW-1:0]     FMAX  = FHALF - MAGW'(1);
  localparam logic [EVW-1:0]      EMAX  = EVW'({ENERGY_W{1'b1}});

  logic [UF:0]    vld_q;
  logic [RTW-1:0] root_q [UF+1];
  logic           free_q [UF+1];
  logic           pos_q  [UF+1][3];
  logic           cap_q  [UF+1][3];
  logic [UF-1:0]  q_q    [UF+1][3];
  logic [RTW-1:0] r_q    [UF][3];
  logic [AW-1:0]  ad     [3];
  logic [RTW-1:0] n_d    [3];
  logic [RTW:0]   rin    [UF][3];
  logic           ge     [UF][3];
  logic [RTW-1:0] rnx    [UF][3];
  logic [UW-1:0]  u      [3];
  logic [PW-1:0]  p_d    [3];
  logic [EPW-1:0] e_d;

  logic           vld_m_q;
  logic [PW-1:0]  p_m_q  [3];
  logic [EPW-1:0] e_m_q;
  logic           pos_m_q [3];
  logic           zero_m_q;
  logic           free_m_q;

  logic [PW:0]    psum [3];
  logic [MAGW-1:0] mag [3];
  logic [MAGW-1:0] nmag [3];
  logic [EPW:0]   esum;
  logic [EVW-1:0] ev;
  logic [2:0][FORCE_W-1:0] f_d;
  logic [ENERGY_W-1:0] en_d;

  logic                    vld_out_q;
  logic [2:0][FORCE_W-1:0] force_q;
  logic [ENERGY_W-1:0]     energy_q;
  logic                    free_out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad[i]  = d_i[i][DW-1] ? AW'(-d_i[i]) : AW'(d_i[i]);
      n_d[i] = {ad[i], {GUARD{1'b0}}};
    end
    for (int k = 0; k < UF; k++) begin
      for (int i = 0; i < 3; i++) begin
        rin[k][i] = {r_q[k][i], 1'b0};
        ge[k][i]  = rin[k][i] >= {1'b0, root_q[k]};
        rnx[k][i] = ge[k][i] ? RTW'(rin[k][i] - {1'b0, root_q[k]}) : rin[k][i][RTW-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      u[i]   = cap_q[UF][i] ? UCAP : {1'b0, q_q[UF][i]};
      p_d[i] = stiffness_i * u[i];
    end
    e_d = stiffness_i * root_q[UF];
    for (int i = 0; i < 3; i++) begin
      psum[i] = {1'b0, p_m_q[i]} + HALFU;
      mag[i]  = psum[i][PW:UF];
      nmag[i] = MAGW'(0) - mag[i];
      if (zero_m_q) begin
        f_d[i] = '0;
      end else if (pos_m_q[i]) begin
        f_d[i] = (mag[i] > FHALF) ? FHALF[FORCE_W-1:0] : nmag[i][FORCE_W-1:0];
      end else begin
        f_d[i] = (mag[i] > FMAX) ? FMAX[FORCE_W-1:0] : mag[i][FORCE_W-1:0];
      end
    end
    esum = {1'b0, e_m_q} + HALFE;
    ev   = esum[EPW:ESH];
    if (zero_m_q) begin
      en_d = '0;
    end else if (ev > EMAX) begin
      en_d = '1;
    end else begin
      en_d = ev[ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_m_q   <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[UF-1:0], valid_i};
      vld_m_q   <= vld_q[UF];
      vld_out_q <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q[0] <= root_i;
      free_q[0] <= free_i;
      for (int i = 0; i < 3; i++) begin
        pos_q[0][i] <= !d_i[i][DW-1] && (d_i[i] != '0);
        cap_q[0][i] <= n_d[i] >= root_i;
        q_q[0][i]   <= '0;
        r_q[0][i]   <= n_d[i];
      end
      for (int k = 0; k < UF; k++) begin
        root_q[k+1] <= root_q[k];
        free_q[k+1] <= free_q[k];
        for (int i = 0; i < 3; i++) begin
          pos_q[k+1][i] <= pos_q[k][i];
          cap_q[k+1][i] <= cap_q[k][i];
          q_q[k+1][i]   <= {q_q[k][i][UF-2:0], ge[k][i]};
        end
      end
      for (int k = 0; k < UF - 1; k++) begin
        for (int i = 0; i < 3; i++) begin
          r_q[k+1][i] <= rnx[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        p_m_q[i]   <= p_d[i];
        pos_m_q[i] <= pos_q[UF][i];
      end
      e_m_q      <= e_d;
      zero_m_q   <= free_q[UF] || (root_q[UF] == '0);
      free_m_q   <= free_q[UF];
      force_q    <= f_d;
      energy_q   <= en_d;
      free_out_q <= free_m_q;
    end
  end

  assign valid_o  = vld_out_q;
  assign force_o  = force_q;
  assign energy_o = energy_q;
  assign free_o   = free_out_q;

endmodule

// ----- hw/rtl/ellipsoid_shell_repulsion_force.sv -----
// throughput: one particle per cycle while no output stall holds the pipeline;
// remainder, quotient and root units retire one digit a stage
// m_axis_tready low with a result waiting freezes the whole pipeline and drops s_axis_tready
// in the same cycle
// reset: rst_ni asynchronous active low, clears all valid bits and loads register defaults
`include "ellipsoid_shell_repulsion_force_macros.svh"

module ellipsoid_shell_repulsion_force (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [esrf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [esrf_pkg::REG_W-1:0]            cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, pos_z, zero fill
  input  logic [esrf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // force_x, force_y, force_z, energy
  output logic [esrf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // in_free_shell
  output logic [0:0]                            m_axis_tuser
);
  import esrf_pkg::*;

  cfg_t   cfg_q;
  logic   en;
  logic [2:0][COORD_WIDTH-1:0] pos;

  logic   w_valid, s_valid, q_valid;
  disp3_t w_d, s_d, q_d;
  logic [SW-1:0]  s_sum;
  logic           s_free, q_free;
  logic [RTW-1:0] q_root;
  logic [2:0][FORCE_W-1:0] force_w;
  logic [ENERGY_W-1:0]     energy_w;
  logic                    free_w;
  logic                    out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness <= '0;
      cfg_q.center    <= '0;
      cfg_q.inner     <= INNER_RESET;
      cfg_q.outer     <= OUTER_RESET;
      cfg_q.box       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STIFFNESS: cfg_q.stiffness <= cfg_wdata_i[STIFF_W-1:0];
        CFG_CENTER:    cfg_q.center    <= cfg_wdata_i;
        CFG_INNER:     cfg_q.inner     <= cfg_wdata_i;
        CFG_OUTER:     cfg_q.outer     <= cfg_wdata_i;
        CFG_BOX:       cfg_q.box       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  esrf_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pos_i   (pos),
    .cfg_i   (cfg_q),
    .valid_o (w_valid),
    .d_o     (w_d)
  );

  esrf_shell u_shell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (w_valid),
    .d_i     (w_d),
    .cfg_i   (cfg_q),
    .valid_o (s_valid),
    .d_o     (s_d),
    .s_o     (s_sum),
    .free_o  (s_free)
  );

  esrf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .d_i     (s_d),
    .s_i     (s_sum),
    .free_i  (s_free),
    .valid_o (q_valid),
    .d_o     (q_d),
    .root_o  (q_root),
    .free_o  (q_free)
  );

  esrf_force u_force (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (q_valid),
    .d_i         (q_d),
    .root_i      (q_root),
    .free_i      (q_free),
    .stiffness_i (cfg_q.stiffness),
    .valid_o     (out_valid),
    .force_o     (force_w),
    .energy_o    (energy_w),
    .free_o      (free_w)
  );

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = OUT_TDATA_W'({energy_w, force_w[2], force_w[1], force_w[0]});
  assign m_axis_tuser[0] = free_w;

  `ESRF_ASSERT(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
  `ESRF_ASSERT(a_free_is_quiet, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
  `ESRF_ASSERT_NEVER(a_no_stiffness_no_force,
    m_axis_tvalid && (cfg_q.stiffness == '0) && (m_axis_tdata != '0))

endmodule
